@@ src/srs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the speed ramp shaper.
// No dependencies; imported by srs_muldiv and speed_ramp_shaper_top.
package srs_pkg;

  localparam int unsigned OpWidth    = 32;
  localparam int unsigned ProdWidth  = 2 * OpWidth;
  localparam int unsigned CntWidth   = $clog2(ProdWidth);

  localparam logic [OpWidth-1:0] US_PER_SEC = 32'd1000000;

  localparam logic [27:0] ACC_MAX = 28'h7FFFFFF;
  localparam logic [27:0] ACC_MIN = 28'h8000000;

  localparam logic [14:0] MAX_SPEED_RST = 15'd25600;

  typedef enum logic [2:0] {
    REG_PROFILE_MODE = 3'd0,
    REG_SHAPING_EN   = 3'd1,
    REG_MAX_SPEED    = 3'd2,
    REG_ACCEL_LIMIT  = 3'd3,
    REG_JERK_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_SHAPE = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_TRAP   = 1'b0,
    MODE_SCURVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRAP,
    ST_ATGT,
    ST_SCAP,
    ST_ACC,
    ST_VEL,
    ST_DONE
  } state_t;

  // Request to the multiply-divide unit: floor(a * b / d)
  typedef struct packed {
    logic               start;
    logic [OpWidth-1:0] a;
    logic [OpWidth-1:0] b;
    logic [OpWidth-1:0] d;
  } md_req_t;

endpackage

@@ src/srs_muldiv.sv @@
`timescale 1ns / 1ps
// Bit-serial unsigned multiply then divide: quo = floor(a * b / d).
// Depends on srs_pkg. One multiplier bit, then one quotient bit per cycle.
module srs_muldiv
  import srs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  md_req_t              req,
  output logic                 done,
  output logic [ProdWidth-1:0] quo
);

  md_state_t            state_r, state_nxt;
  logic [CntWidth-1:0]  cnt_r, cnt_nxt;
  logic [OpWidth-1:0]   a_r, a_nxt;
  logic [OpWidth-1:0]   d_r, d_nxt;
  logic [ProdWidth-1:0] prod_r, prod_nxt;
  logic [OpWidth:0]     rem_r, rem_nxt;
  logic                 done_r, done_nxt;
  logic [OpWidth:0]     sum;
  logic [OpWidth:0]     shifted;
  logic                 ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    sum       = {1'b0, prod_r[ProdWidth-1:OpWidth]} +
                (prod_r[0] ? {1'b0, a_r} : '0);
    shifted   = {rem_r[OpWidth-1:0], prod_r[ProdWidth-1]};
    ge        = (shifted >= {1'b0, d_r});
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          a_nxt     = req.a;
          d_nxt     = req.d;
          prod_nxt  = {{OpWidth{1'b0}}, req.b};
          cnt_nxt   = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        // add and shift right; multiplier bits drain from the bottom
        prod_nxt = {sum, prod_r[OpWidth-1:1]};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CntWidth'(OpWidth - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        // restoring step; quotient bits fill in from the bottom
        rem_nxt  = ge ? (shifted - {1'b0, d_r}) : shifted;
        prod_nxt = {prod_r[ProdWidth-2:0], ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CntWidth'(ProdWidth - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  assign done = done_r;
  assign quo  = prod_r;

endmodule

@@ src/speed_ramp_shaper_top.sv @@
`timescale 1ns / 1ps
// Speed ramp shaper top level: trapezoid or jerk-limited S-curve speed profile.
// Depends on srs_pkg and srs_muldiv.

// Takes one transaction at a time. A clear or a pass-through transaction
// (shaping disabled) goes straight from idle to the done state. Every
// product with the time step and every division goes through one shared
// bit-serial multiply-divide unit, which steps through the 32 multiplier
// bits and then the 64 quotient bits of each use (one use for trapezoid,
// three for S-curve). The output register holds a finished result while
// the next transaction is taken.
module speed_ramp_shaper_top
  import srs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [15:0] in_target_speed,
  input  logic        [31:0] in_time_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_shaped_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [27:0] cfg_data
);

  // configuration
  logic        mode_r;
  logic        enabled_r;
  logic [14:0] max_speed_r;
  logic [23:0] accel_limit_r;
  logic [27:0] jerk_limit_r;

  state_t state_r, state_nxt;
  logic signed [15:0] speed_r, speed_nxt;
  logic signed [27:0] accel_r, accel_nxt;
  logic        [31:0] last_r, last_nxt;
  logic        [31:0] dt_r, dt_nxt;
  logic signed [16:0] tc_r, tc_nxt;
  logic signed [16:0] err_r, err_nxt;
  logic signed [25:0] atgt_r, atgt_nxt;
  logic signed [28:0] step_r, step_nxt;
  logic signed [27:0] acc_r, acc_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_data_r;
  logic               load_out;

  md_req_t                md_req;
  logic                   md_done;
  logic [ProdWidth-1:0]   md_quo;

  // combinational helpers
  logic signed [16:0] tgt17, mx17, tc_c, err_c;
  logic        [16:0] err_mag;
  logic               q_big17;
  logic        [16:0] q17;
  logic signed [17:0] d_c, spd18;
  logic        [23:0] capped;
  logic signed [28:0] diff;
  logic        [28:0] diff_mag;
  logic        [27:0] sc;
  logic signed [29:0] acc_sum;
  logic signed [27:0] acc_c;
  logic        [27:0] acc_mag;
  logic signed [18:0] sv, ns, tc19;

  srs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .quo   (md_quo)
  );

  // hold off writes while in reset
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_TRAP;
      enabled_r     <= 1'b0;
      max_speed_r   <= MAX_SPEED_RST;
      accel_limit_r <= '0;
      jerk_limit_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROFILE_MODE: mode_r        <= cfg_data[0];
        REG_SHAPING_EN:   enabled_r     <= cfg_data[0];
        REG_MAX_SPEED:    max_speed_r   <= cfg_data[14:0];
        REG_ACCEL_LIMIT:  accel_limit_r <= cfg_data[23:0];
        REG_JERK_LIMIT:   jerk_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      speed_r <= '0;
      accel_r <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      speed_r <= speed_nxt;
      accel_r <= accel_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    tc_r   <= tc_nxt;
    err_r  <= err_nxt;
    atgt_r <= atgt_nxt;
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res_r;
    end
  end

  assign in_ready         = rst_n && (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_shaped_speed = out_data_r;

  always_comb begin
    state_nxt = state_r;
    speed_nxt = speed_r;
    accel_nxt = accel_r;
    last_nxt  = last_r;
    dt_nxt    = dt_r;
    tc_nxt    = tc_r;
    err_nxt   = err_r;
    atgt_nxt  = atgt_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    load_out  = 1'b0;
    md_req    = '0;

    // target clamp and speed error
    tgt17 = {in_target_speed[15], in_target_speed};
    mx17  = {2'b00, max_speed_r};
    if (tgt17 > mx17) begin
      tc_c = mx17;
    end else if (tgt17 < -mx17) begin
      tc_c = -mx17;
    end else begin
      tc_c = tgt17;
    end
    err_c   = tc_c - {speed_r[15], speed_r};
    err_mag = err_r[16] ? 17'(-err_r) : 17'(err_r);

    q_big17 = |md_quo[ProdWidth-1:17];
    q17     = md_quo[16:0];

    // trapezoid step
    if (q_big17 || (q17 >= err_mag)) begin
      d_c = {err_r[16], err_r};
    end else begin
      d_c = err_r[16] ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
    end
    spd18 = {speed_r[15], speed_r[15], speed_r} + d_c;

    // acceleration target cap
    if ((|md_quo[ProdWidth-1:24]) || (md_quo[23:0] > accel_limit_r)) begin
      capped = accel_limit_r;
    end else begin
      capped = md_quo[23:0];
    end
    if (dt_r == '0) begin
      capped = '0;
    end

    // jerk cap
    diff     = {{3{atgt_r[25]}}, atgt_r} - {accel_r[27], accel_r};
    diff_mag = diff[28] ? 29'(-diff) : 29'(diff);
    sc       = (|md_quo[ProdWidth-1:28]) ? '1 : md_quo[27:0];

    // new acceleration with saturation
    acc_sum = {{2{accel_r[27]}}, accel_r} + {step_r[28], step_r};
    if (acc_sum > $signed({{2{ACC_MAX[27]}}, ACC_MAX})) begin
      acc_c = ACC_MAX;
    end else if (acc_sum < $signed({{2{ACC_MIN[27]}}, ACC_MIN})) begin
      acc_c = ACC_MIN;
    end else begin
      acc_c = acc_sum[27:0];
    end
    acc_mag = acc_c[27] ? 28'(-acc_c) : 28'(acc_c);

    // speed advance
    sv   = acc_r[27] ? -$signed({2'b00, q17}) : $signed({2'b00, q17});
    if (q_big17) begin
      sv = acc_r[27] ? -19'sd131071 : 19'sd131071;
    end
    ns   = {{3{speed_r[15]}}, speed_r} + sv;
    tc19 = {{2{tc_r[16]}}, tc_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_CLEAR) begin
            speed_nxt = '0;
            accel_nxt = '0;
            last_nxt  = '0;
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else if (!enabled_r) begin
            speed_nxt = in_target_speed;
            last_nxt  = in_time_us;
            res_nxt   = in_target_speed;
            state_nxt = ST_DONE;
          end else begin
            dt_nxt   = (last_r == '0) ? '0 : (in_time_us - last_r);
            last_nxt = in_time_us;
            tc_nxt   = tc_c;
            err_nxt  = err_c;
            md_req.start = 1'b1;
            if (mode_r == MODE_TRAP) begin
              md_req.a  = {8'd0, accel_limit_r};
              md_req.b  = dt_nxt;
              md_req.d  = US_PER_SEC;
              state_nxt = ST_TRAP;
            end else begin
              md_req.a  = err_c[16] ? 32'(-err_c) : 32'(err_c);
              md_req.b  = US_PER_SEC;
              md_req.d  = dt_nxt;
              state_nxt = ST_ATGT;
            end
          end
        end
      end
      ST_TRAP: begin
        if (md_done) begin
          speed_nxt = spd18[15:0];
          res_nxt   = spd18[15:0];
          state_nxt = ST_DONE;
        end
      end
      ST_ATGT: begin
        if (md_done) begin
          atgt_nxt = err_r[16] ? -$signed({2'b00, capped}) : $signed({2'b00, capped});
          md_req.start = 1'b1;
          md_req.a     = {4'd0, jerk_limit_r};
          md_req.b     = dt_r;
          md_req.d     = US_PER_SEC;
          state_nxt    = ST_SCAP;
        end
      end
      ST_SCAP: begin
        if (md_done) begin
          if (diff_mag <= {1'b0, sc}) begin
            step_nxt = diff;
          end else begin
            step_nxt = diff[28] ? -$signed({1'b0, sc}) : $signed({1'b0, sc});
          end
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_nxt      = acc_c;
        md_req.start = 1'b1;
        md_req.a     = {4'd0, acc_mag};
        md_req.b     = dt_r;
        md_req.d     = US_PER_SEC;
        state_nxt    = ST_VEL;
      end
      ST_VEL: begin
        if (md_done) begin
          accel_nxt = acc_r;
          // stop at the target without overshoot
          if (((err_r > 0) && (ns > tc19)) || ((err_r < 0) && (ns < tc19))) begin
            ns        = tc19;
            accel_nxt = '0;
          end
          if (ns > 19'sd32767) begin
            speed_nxt = 16'sh7FFF;
          end else if (ns < -19'sd32768) begin
            speed_nxt = 16'sh8000;
          end else begin
            speed_nxt = ns[15:0];
          end
          res_nxt   = speed_nxt;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
